// File: design/osmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osmt_pkg
// Types and constants shared by the ordered set membership table and its cells.
// ----------------------------------------------------------------------------
package osmt_pkg;

  localparam int CAPACITY   = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } osmt_cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } osmt_state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] element;
  } osmt_in_t;

  typedef struct packed {
    logic       was_present;
    logic [4:0] member_count;
    logic       full_refused;
  } osmt_out_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                  cmp_en;
    logic                  upd_en;
    osmt_cmd_e             cmd;
    logic [ELEM_WIDTH-1:0] cmp_elem;
    logic [ELEM_WIDTH-1:0] upd_elem;
    logic                  any_found;
  } osmt_ctl_t;

endpackage
`default_nettype wire

// File: design/ordered_set_membership_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_set_membership_table
// Ordered set of up to CAPACITY distinct elements with insert, remove, query
// and clear commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Each command has a
// compare step and an update step: in the accept cycle each cell compares
// the element against its entry, and in the next cycle the row of cells
// shifts down past a removed entry or the tail cell stores an inserted one.
// Exactly one result follows, shown for a single cycle with out_valid the
// cycle after the update; the receiver cannot stall it, and a new command
// may be started in that same cycle, but none is taken during the update.
// The set is empty after reset.
module ordered_set_membership_table (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  osmt_pkg::osmt_in_t   in_data,
  output logic                 out_valid,
  output osmt_pkg::osmt_out_t  out_data
);
  import osmt_pkg::*;

  osmt_state_e          state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  osmt_cmd_e            cmd_r, cmd_nxt;
  logic [ELEM_WIDTH-1:0] elem_r, elem_nxt;
  logic                 out_valid_r, out_valid_nxt;
  osmt_out_t            out_data_r, out_data_nxt;

  logic                  accept;
  logic                  upd_en;
  logic                  found;
  logic                  full;
  osmt_ctl_t             ctl;
  logic [CAPACITY:0]     found_chain;
  logic [ELEM_WIDTH-1:0] entry [CAPACITY];

  assign accept = start && (state_r == ST_IDLE);
  assign found  = found_chain[CAPACITY];
  assign full   = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    ctl.cmp_en    = accept;
    ctl.upd_en    = upd_en;
    ctl.cmd       = cmd_r;
    ctl.cmp_elem  = in_data.element[ELEM_WIDTH-1:0];
    ctl.upd_elem  = elem_r;
    ctl.any_found = found;
  end

  assign found_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] next_entry;
    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = entry[i];
    end else begin : g_mid
      assign next_entry = entry[i+1];
    end
    osmt_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .active     (CNT_W'(i) < count_r),
      .is_tail    (CNT_W'(i) == count_r),
      .next_entry (next_entry),
      .found_in   (found_chain[i]),
      .found_out  (found_chain[i+1]),
      .entry      (entry[i])
    );
  end

  // control
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    elem_nxt      = elem_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    upd_en        = 1'b0;
    busy          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt   = osmt_cmd_e'(in_data.cmd);
          elem_nxt  = in_data.element[ELEM_WIDTH-1:0];
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        busy                      = 1'b1;
        upd_en                    = 1'b1;
        out_valid_nxt             = 1'b1;
        out_data_nxt.was_present  = found;
        out_data_nxt.full_refused = 1'b0;
        case (cmd_r)
          CMD_INSERT: begin
            if (!found) begin
              if (full) begin
                out_data_nxt.full_refused = 1'b1;
              end else begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
          end
          CMD_REMOVE: begin
            if (found) begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
          CMD_CLEAR: begin
            out_data_nxt.was_present = 1'b0;
            count_nxt                = '0;
          end
          default: begin
            count_nxt = count_r;
          end
        endcase
        out_data_nxt.member_count = 5'(count_nxt);
        state_nxt                 = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    elem_r     <= elem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.member_count <= 5'(CAPACITY)))
    else $error("member count beyond capacity");

  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (!busy && out_valid))
    else $error("update did not finish in one cycle");

  a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.full_refused) |-> (out_data.member_count == 5'(CAPACITY)))
    else $error("insert refused while set not full");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not enter update");

endmodule
`default_nettype wire

// File: design/osmt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osmt_cell
// One slot of the table: holds an entry, compares it against the broadcast
// element, shifts in its right neighbor's entry on remove, stores on insert.
// ----------------------------------------------------------------------------
module osmt_cell (
  input  wire                                clk,
  input  osmt_pkg::osmt_ctl_t                ctl,
  input  wire                                active,
  input  wire                                is_tail,
  input  wire  [osmt_pkg::ELEM_WIDTH-1:0]    next_entry,
  input  wire                                found_in,
  output logic                               found_out,
  output logic [osmt_pkg::ELEM_WIDTH-1:0]    entry
);
  import osmt_pkg::*;

  logic [ELEM_WIDTH-1:0] entry_r;
  logic [ELEM_WIDTH-1:0] entry_nxt;
  logic                  match_r;
  logic                  match_nxt;

  always_comb begin
    match_nxt = match_r;
    if (ctl.cmp_en) begin
      match_nxt = active && (entry_r == ctl.cmp_elem);
    end
  end

  assign found_out = found_in | match_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.upd_en) begin
      case (ctl.cmd)
        CMD_REMOVE: begin
          if (found_out) begin
            entry_nxt = next_entry;
          end
        end
        CMD_INSERT: begin
          if (!ctl.any_found && is_tail) begin
            entry_nxt = ctl.upd_elem;
          end
        end
        default: begin
          entry_nxt = entry_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign entry = entry_r;

endmodule
`default_nettype wire
